// File: design/pmes_pkg.sv
package pmes_pkg;

  localparam int MAX_DIM     = 64;
  localparam int STORE_DEPTH = 4096;
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = VALUE_WIDTH / 2;
  localparam int WORD_W      = 2 * VALUE_WIDTH;
  localparam int ACC_W       = 2 * VALUE_WIDTH + 1;

  localparam int COORD_W  = 6;
  localparam int DIM_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM * MAX_DIM) + 1;

  localparam int QDEPTH = 2;

  localparam logic [1:0] OP_GET   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_SCALE = 2'd3;

  localparam logic [1:0] SM_NORMAL = 2'd0;
  localparam logic [1:0] SM_SYM    = 2'd1;
  localparam logic [1:0] SM_HERM   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STORAGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd3;

  typedef struct packed {
    logic [1:0]                    op;
    logic [COORD_W-1:0]            row;
    logic [COORD_W-1:0]            col;
    logic signed [VALUE_WIDTH-1:0] value_real;
    logic signed [VALUE_WIDTH-1:0] value_imag;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] read_real;
    logic signed [VALUE_WIDTH-1:0] read_imag;
    logic                          error;
  } out_rsp_t;

  typedef struct packed {
    logic [1:0]                    op;
    logic [ADDR_W-1:0]             addr;
    logic                          error;
    logic                          flipped;
    logic                          cplx;
    logic signed [VALUE_WIDTH-1:0] vr;
    logic signed [VALUE_WIDTH-1:0] vi;
  } qent_t;

endpackage

// File: design/pmes_ram.sv
module pmes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/pmes_queue.sv
module pmes_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pmes_pkg::qent_t   push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output pmes_pkg::qent_t   head
);

  localparam int PTR_W = (pmes_pkg::QDEPTH > 1) ? $clog2(pmes_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(pmes_pkg::QDEPTH + 1);

  pmes_pkg::qent_t  slot_r [0:pmes_pkg::QDEPTH-1];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(pmes_pkg::QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(pmes_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(pmes_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

// File: design/pmes_front.sv
module pmes_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pmes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pmes_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pmes_pkg::in_req_t                   in_data,
  input  logic                                q_full,
  input  logic                                clear_done,
  output logic                                q_push,
  output pmes_pkg::qent_t                     q_entry
);

  localparam int IW = pmes_pkg::IDX_W;

  logic                           complex_mode_r, complex_mode_nxt;
  logic [1:0]                     storage_mode_r, storage_mode_nxt;
  logic [pmes_pkg::DIM_W-1:0]     num_rows_r, num_rows_nxt;
  logic [pmes_pkg::DIM_W-1:0]     num_cols_r, num_cols_nxt;

  logic [pmes_pkg::DIM_W-1:0]     nr, nc;
  logic                           packed_mode, herm, swap, range_err, err;
  logic [pmes_pkg::COORD_W-1:0]   r, c;
  logic [IW-1:0]                  idx;

  always_comb begin
    complex_mode_nxt = complex_mode_r;
    storage_mode_nxt = storage_mode_r;
    num_rows_nxt     = num_rows_r;
    num_cols_nxt     = num_cols_r;
    if (cfg_we) begin
      case (cfg_index)
        pmes_pkg::CFG_COMPLEX:  complex_mode_nxt = cfg_data[0];
        pmes_pkg::CFG_STORAGE:  storage_mode_nxt = cfg_data[1:0];
        pmes_pkg::CFG_NUM_ROWS: num_rows_nxt     = cfg_data;
        pmes_pkg::CFG_NUM_COLS: num_cols_nxt     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complex_mode_r <= 1'b0;
      storage_mode_r <= pmes_pkg::SM_NORMAL;
      num_rows_r     <= pmes_pkg::DIM_W'(64);
      num_cols_r     <= pmes_pkg::DIM_W'(64);
    end else begin
      complex_mode_r <= complex_mode_nxt;
      storage_mode_r <= storage_mode_nxt;
      num_rows_r     <= num_rows_nxt;
      num_cols_r     <= num_cols_nxt;
    end
  end

  always_comb begin
    nr = (32'(num_rows_r) > 32'(pmes_pkg::MAX_DIM)) ?
         pmes_pkg::DIM_W'(pmes_pkg::MAX_DIM) : num_rows_r;
    nc = (32'(num_cols_r) > 32'(pmes_pkg::MAX_DIM)) ?
         pmes_pkg::DIM_W'(pmes_pkg::MAX_DIM) : num_cols_r;
    packed_mode = ((storage_mode_r == pmes_pkg::SM_SYM) ||
                   (storage_mode_r == pmes_pkg::SM_HERM)) && (nr == nc);
    herm = packed_mode && (storage_mode_r == pmes_pkg::SM_HERM) && complex_mode_r;
    range_err = ({1'b0, in_data.row} >= nr) || ({1'b0, in_data.col} >= nc);
    swap = packed_mode && (in_data.row > in_data.col);
    r = swap ? in_data.col : in_data.row;
    c = swap ? in_data.row : in_data.col;
    if (packed_mode) begin
      idx = IW'(r) + ((IW'(c) * (IW'(c) + 1'b1)) >> 1);
    end else begin
      idx = IW'(r) + IW'(c) * IW'(nr);
    end
    err = range_err || (32'(idx) >= 32'(pmes_pkg::STORE_DEPTH));
  end

  assign in_ready = !q_full && clear_done;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_entry.op      = in_data.op;
    q_entry.addr    = pmes_pkg::ADDR_W'(idx);
    q_entry.error   = err;
    q_entry.flipped = swap && herm && !err;
    q_entry.cplx    = complex_mode_r;
    q_entry.vr      = in_data.value_real;
    q_entry.vi      = complex_mode_r ? in_data.value_imag : '0;
  end

endmodule

// File: design/pmes_back.sv
module pmes_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  pmes_pkg::qent_t   q_head,
  output logic              q_pop,
  output logic              clear_done,
  output logic              out_valid,
  input  logic              out_ready,
  output pmes_pkg::out_rsp_t out_data
);

  localparam int W  = pmes_pkg::VALUE_WIDTH;
  localparam int AW = pmes_pkg::ADDR_W;
  localparam int AC = pmes_pkg::ACC_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;

  localparam logic [2:0] MUL_LAST = 3'd4;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] x);
    neg_sat = (x == VMIN) ? VMAX : -x;
  endfunction

  function automatic logic signed [W-1:0] add_sat(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      add_sat = s[W] ? VMIN : VMAX;
    end else begin
      add_sat = s[W-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] acc_sat(input logic signed [AC-1:0] a);
    logic signed [AC-1:0] s;
    s = a >>> pmes_pkg::FRAC_BITS;
    if ((&s[AC-1:W-1]) || !(|s[AC-1:W-1])) begin
      acc_sat = s[W-1:0];
    end else begin
      acc_sat = s[AC-1] ? VMIN : VMAX;
    end
  endfunction

  logic [2:0]                state_r, state_nxt;
  logic [AW-1:0]             clr_addr_r, clr_addr_nxt;
  logic [2:0]                step_r, step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  pmes_pkg::out_rsp_t        out_data_r, out_data_nxt;
  pmes_pkg::qent_t           cur_r, cur_nxt;
  logic signed [W-1:0]       er_r, er_nxt, ei_r, ei_nxt;
  logic signed [W-1:0]       nv_re_r, nv_re_nxt, nv_im_r, nv_im_nxt;
  logic signed [2*W-1:0]     prod_r, prod_nxt;
  logic signed [AC-1:0]      acc_re_r, acc_re_nxt, acc_im_r, acc_im_nxt;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [pmes_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  logic signed [W-1:0]       rd_re, rd_im_raw, mul_a, mul_b, si, out_im;
  logic signed [AC-1:0]      prod_ext;
  logic                      out_free;

  pmes_ram #(
    .WIDTH (pmes_pkg::WORD_W),
    .DEPTH (pmes_pkg::STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free   = !out_valid_r || out_ready;
  assign clear_done = (state_r != S_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    rd_re     = ram_rdata[W-1:0];
    rd_im_raw = cur_r.cplx ? ram_rdata[2*W-1:W] : '0;
    case (step_r)
      3'd0:    begin mul_a = er_r; mul_b = cur_r.vr; end
      3'd1:    begin mul_a = ei_r; mul_b = cur_r.vi; end
      3'd2:    begin mul_a = er_r; mul_b = cur_r.vi; end
      default: begin mul_a = ei_r; mul_b = cur_r.vr; end
    endcase
    prod_ext = {prod_r[2*W-1], prod_r};
    si       = cur_r.flipped ? neg_sat(nv_im_r) : nv_im_r;
    if (cur_r.op == pmes_pkg::OP_GET) begin
      out_im = nv_im_r;
    end else begin
      out_im = cur_r.flipped ? neg_sat(si) : si;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cur_nxt       = cur_r;
    er_nxt        = er_r;
    ei_nxt        = ei_r;
    nv_re_nxt     = nv_re_r;
    nv_im_nxt     = nv_im_r;
    prod_nxt      = prod_r;
    acc_re_nxt    = acc_re_r;
    acc_im_nxt    = acc_im_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cur_r.addr;
    ram_wdata     = {si, nv_re_r};
    ram_re        = 1'b0;
    ram_raddr     = q_head.addr;
    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(pmes_pkg::STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          if (q_head.error) begin
            nv_re_nxt = '0;
            nv_im_nxt = '0;
            state_nxt = S_WB;
          end else begin
            ram_re    = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        er_nxt    = rd_re;
        ei_nxt    = cur_r.flipped ? neg_sat(rd_im_raw) : rd_im_raw;
        step_nxt  = '0;
        state_nxt = (cur_r.op == pmes_pkg::OP_SCALE) ? S_MUL : S_FIN;
      end
      S_MUL: begin
        prod_nxt = mul_a * mul_b;
        case (step_r)
          3'd1:    acc_re_nxt = prod_ext;
          3'd2:    acc_re_nxt = acc_re_r - prod_ext;
          3'd3:    acc_im_nxt = prod_ext;
          3'd4:    acc_im_nxt = acc_im_r + prod_ext;
          default: ;
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r == MUL_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        case (cur_r.op)
          pmes_pkg::OP_SET: begin
            nv_re_nxt = cur_r.vr;
            nv_im_nxt = cur_r.vi;
          end
          pmes_pkg::OP_ADD: begin
            nv_re_nxt = add_sat(er_r, cur_r.vr);
            nv_im_nxt = add_sat(ei_r, cur_r.vi);
          end
          pmes_pkg::OP_SCALE: begin
            nv_re_nxt = acc_sat(acc_re_r);
            nv_im_nxt = acc_sat(acc_im_r);
          end
          default: begin
            nv_re_nxt = er_r;
            nv_im_nxt = ei_r;
          end
        endcase
        if (!cur_r.cplx) begin
          nv_im_nxt = '0;
        end
        state_nxt = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          ram_we                 = !cur_r.error && (cur_r.op != pmes_pkg::OP_GET);
          out_valid_nxt          = 1'b1;
          out_data_nxt.read_real = nv_re_r;
          out_data_nxt.read_imag = out_im;
          out_data_nxt.error     = cur_r.error;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cur_r      <= cur_nxt;
    er_r       <= er_nxt;
    ei_r       <= ei_nxt;
    nv_re_r    <= nv_re_nxt;
    nv_im_r    <= nv_im_nxt;
    prod_r     <= prod_nxt;
    acc_re_r   <= acc_re_nxt;
    acc_im_r   <= acc_im_nxt;
  end

endmodule

// File: design/packed_matrix_entry_store.sv
// Channel   Ports                           Moves
// in        in_valid/in_ready/in_data       access request (op, row, col, value)
// out       out_valid/out_ready/out_data    entry after the request, error flag
// cfg       cfg_we/cfg_index/cfg_data       register write, no wait
//
// Scale adds multiply steps in the back end (one shared 32x32 multiplier over
// four products); an out-of-range request skips the read and goes to write-back.
// The back end takes one request at a time through read, update and write-back.
// After reset a clearing pass writes all 4096 entries, one per cycle; no request
// is taken until it ends. A two-entry queue keeps accepting while the back end
// works or the output register waits on out_ready.
module packed_matrix_entry_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pmes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmes_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pmes_pkg::in_req_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pmes_pkg::out_rsp_t               out_data
);

  logic            q_full, q_push, q_pop, q_valid, clear_done;
  pmes_pkg::qent_t q_entry, q_head;

  pmes_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .clear_done (clear_done),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  pmes_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  pmes_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .clear_done (clear_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
